>>> hdl/mcaam_pkg.sv
// shared constants, codes and types for the multichannel adc averager
package mcaam_pkg;

    localparam int NUM_CHANNELS = 13;
    localparam int SAMPLE_W     = 12;
    localparam int CH_W         = 4;
    localparam int AVG_W        = 16;
    localparam int GAIN_W       = 12;
    localparam int TOL_W        = 8;
    localparam int MASK_W       = 4;
    localparam int MIC_W        = 8;
    localparam int PROD_W       = SAMPLE_W + GAIN_W;
    localparam int MIC_PROD_W   = AVG_W + GAIN_W;
    localparam int MIC_SHIFT    = 10;
    localparam int DIV_CNT_W    = $clog2(AVG_W);

    localparam logic [GAIN_W-1:0] ANT_SCALE_RST = GAIN_W'(666);
    localparam logic [GAIN_W-1:0] SUP_GAIN_RST  = GAIN_W'(339);
    localparam logic [GAIN_W-1:0] PLUS_GAIN_RST = GAIN_W'(620);
    localparam logic [TOL_W-1:0]  TOL_RST       = TOL_W'(1);

    localparam logic [CH_W-1:0] CH_MIC_PLUS    = CH_W'(1);
    localparam logic [CH_W-1:0] CH_LEFT_PLUS   = CH_W'(3);
    localparam logic [CH_W-1:0] CH_RIGHT_MINUS = CH_W'(6);
    localparam logic [CH_W-1:0] CH_SUPPLY      = CH_W'(7);
    localparam logic [CH_W-1:0] CH_ANTENNA     = CH_W'(10);

    typedef enum logic [1:0] {
        ACT_SAMPLE = 2'd0,
        ACT_CLEAR  = 2'd1,
        ACT_READ   = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        REG_ANT_SCALE = 2'd0,
        REG_SUP_GAIN  = 2'd1,
        REG_PLUS_GAIN = 2'd2,
        REG_TOL       = 2'd3
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOK,
        ST_DIV,
        ST_UPD,
        ST_RD_SUP,
        ST_RD_PLUS,
        ST_MIC,
        ST_DONE
    } t_state;

endpackage

>>> hdl/mcaam_div.sv
// bit-serial restoring divider for the antenna ratio, one quotient bit per cycle
module mcaam_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [mcaam_pkg::PROD_W-1:0]    i_dividend,
    input  logic [mcaam_pkg::SAMPLE_W-1:0]  i_divisor,
    output logic                            o_done,
    output logic [mcaam_pkg::AVG_W-1:0]     o_quot
);

    logic                              r_busy;
    logic                              r_done;
    logic [mcaam_pkg::DIV_CNT_W-1:0]   r_cnt;
    logic [mcaam_pkg::SAMPLE_W-1:0]    r_rem;
    logic [mcaam_pkg::AVG_W-1:0]       r_dvd;
    logic [mcaam_pkg::AVG_W-1:0]       r_quot;
    logic [mcaam_pkg::SAMPLE_W:0]      trial;
    logic                              qbit;
    logic [mcaam_pkg::SAMPLE_W:0]      diff;

    always_comb begin
        trial = {r_rem, r_dvd[mcaam_pkg::AVG_W-1]};
        qbit  = (trial >= {1'b0, i_divisor});
        diff  = trial - {1'b0, i_divisor};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == mcaam_pkg::DIV_CNT_W'(mcaam_pkg::AVG_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // upper dividend bits are already below the divisor, so 16 steps give the quotient
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= mcaam_pkg::SAMPLE_W'(i_dividend[mcaam_pkg::PROD_W-1:mcaam_pkg::AVG_W]);
            r_dvd <= i_dividend[mcaam_pkg::AVG_W-1:0];
        end else if (r_busy) begin
            r_rem  <= qbit ? diff[mcaam_pkg::SAMPLE_W-1:0] : trial[mcaam_pkg::SAMPLE_W-1:0];
            r_dvd  <= {r_dvd[mcaam_pkg::AVG_W-2:0], 1'b0};
            r_quot <= {r_quot[mcaam_pkg::AVG_W-2:0], qbit};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

>>> hdl/multichannel_adc_averager_monitor_core.sv
// top level: channel average memory, update sequencer, mic current monitor, apb registers
//
//  port group  dir  beat fields (low bit up)
//  s_axis      in   tuser: action[1:0]; tdata: channel, sample, battery_sample, audio_allowed
//  m_axis      out  tdata: average, valid_mask, mic_current
//  apb         in   antenna_scale @0x0, mic_supply_gain @0x4, mic_plus_gain @0x8,
//                   valid_tolerance @0xc
//
// an item passes the look, update, supply read, mic plus read, mic and done states,
// and a divide state after look on an antenna sample needing the serial divider;
// the single memory read port takes the channel, supply and mic plus reads in turn.
// one item is in work at a time; a new beat is taken while the last result waits
// in the output register. reset clears the per-channel valid bits at once.
module multichannel_adc_averager_monitor_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // channel[3:0], sample[15:4], battery_sample[27:16],
                                        // audio_allowed[28], zero[31:29]
    input  logic [1:0]  s_axis_tuser,   // action[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // average[15:0], valid_mask[19:16], mic_current[27:20],
                                        // zero[31:28]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CW = mcaam_pkg::CH_W;
    localparam int SW = mcaam_pkg::SAMPLE_W;
    localparam int AW = mcaam_pkg::AVG_W;
    localparam int GW = mcaam_pkg::GAIN_W;
    localparam int NC = mcaam_pkg::NUM_CHANNELS;
    localparam int PW = mcaam_pkg::PROD_W;
    localparam int MW = mcaam_pkg::MIC_PROD_W;

    // configuration registers
    logic [GW-1:0]                 r_ant_scale;
    logic [GW-1:0]                 r_sup_gain;
    logic [GW-1:0]                 r_plus_gain;
    logic [mcaam_pkg::TOL_W-1:0]   r_tol;
    logic                          cfg_wr;
    mcaam_pkg::t_reg_idx           cfg_idx;

    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = mcaam_pkg::t_reg_idx'(paddr[3:2]);
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ant_scale <= mcaam_pkg::ANT_SCALE_RST;
            r_sup_gain  <= mcaam_pkg::SUP_GAIN_RST;
            r_plus_gain <= mcaam_pkg::PLUS_GAIN_RST;
            r_tol       <= mcaam_pkg::TOL_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                mcaam_pkg::REG_ANT_SCALE: r_ant_scale <= pwdata[GW-1:0];
                mcaam_pkg::REG_SUP_GAIN:  r_sup_gain  <= pwdata[GW-1:0];
                mcaam_pkg::REG_PLUS_GAIN: r_plus_gain <= pwdata[GW-1:0];
                mcaam_pkg::REG_TOL:       r_tol       <= pwdata[mcaam_pkg::TOL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            mcaam_pkg::REG_ANT_SCALE: prdata = 32'(r_ant_scale);
            mcaam_pkg::REG_SUP_GAIN:  prdata = 32'(r_sup_gain);
            mcaam_pkg::REG_PLUS_GAIN: prdata = 32'(r_plus_gain);
            mcaam_pkg::REG_TOL:       prdata = 32'(r_tol);
            default:                  prdata = '0;
        endcase
    end

    // item registers
    mcaam_pkg::t_state   r_state, n_state;
    mcaam_pkg::t_action  r_act;
    logic [CW-1:0]       r_ch;
    logic [SW-1:0]       r_smp;
    logic [SW-1:0]       r_batt;
    logic                r_allow;
    logic [PW-1:0]       r_prod;
    logic [AW-1:0]       r_old;
    logic [AW-1:0]       r_v;
    logic [AW-1:0]       r_avg;
    logic [MW-1:0]       r_pa;
    logic [MW-1:0]       r_pb;
    logic [mcaam_pkg::MASK_W-1:0] r_vmask;
    logic                r_ovld;
    logic [31:0]         r_odata;

    logic                in_acc;
    logic [CW-1:0]       in_ch;
    logic                ch_ok;
    logic                is_audio;
    logic                is_ant;
    logic                ant_sat;
    logic                div_start;
    logic                div_done;
    logic [AW-1:0]       div_quot;
    logic                out_load;

    // average memory with one registered read port
    logic [AW-1:0]       mem [NC];
    logic [NC-1:0]       r_valid;
    logic [CW-1:0]       rd_addr;
    logic [AW-1:0]       r_rdata;
    logic                r_rd_ok;
    logic [AW-1:0]       rd_val;
    logic                mem_we;
    logic [AW-1:0]       wr_data;

    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign in_ch  = s_axis_tdata[3:0];
    assign ch_ok  = ({1'b0, r_ch} < (CW + 1)'(NC));
    assign is_audio = (r_ch >= mcaam_pkg::CH_LEFT_PLUS) && (r_ch <= mcaam_pkg::CH_RIGHT_MINUS);
    assign is_ant   = (r_ch == mcaam_pkg::CH_ANTENNA);
    // quotient above 16 bits exactly when the upper product byte reaches the divisor
    assign ant_sat  = (r_batt == '0) || (SW'(r_prod[PW-1:AW]) >= r_batt);
    assign rd_val   = r_rd_ok ? r_rdata : '0;

    always_comb begin
        rd_addr = mcaam_pkg::CH_SUPPLY;
        if (r_state == mcaam_pkg::ST_IDLE) begin
            rd_addr = ({1'b0, in_ch} < (CW + 1)'(NC)) ? in_ch : '0;
        end else if (r_state == mcaam_pkg::ST_RD_PLUS) begin
            rd_addr = mcaam_pkg::CH_MIC_PLUS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_ch] <= wr_data;
        end
        r_rdata <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ok <= 1'b0;
        end else begin
            r_rd_ok <= r_valid[rd_addr];
        end
    end

    mcaam_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_prod),
        .i_divisor  (r_batt),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // update step
    logic [AW:0]          sum;
    logic [AW-1:0]        new_avg;
    logic [AW-1:0]        smp_ext;
    logic [AW-1:0]        adiff;
    logic                 do_write;
    logic [CW-1:0]        bit_ofs;
    logic [1:0]           bit_pos;
    logic [mcaam_pkg::MASK_W-1:0] n_vmask;

    always_comb begin
        smp_ext  = AW'(r_smp);
        sum      = {1'b0, r_old} + {1'b0, r_v};
        new_avg  = sum[AW:1];
        adiff    = (new_avg >= smp_ext) ? new_avg - smp_ext : smp_ext - new_avg;
        do_write = (r_act == mcaam_pkg::ACT_SAMPLE) && ch_ok;
        bit_ofs  = mcaam_pkg::CH_RIGHT_MINUS - r_ch;
        bit_pos  = bit_ofs[1:0];
        wr_data  = (is_audio && !r_allow) ? smp_ext : new_avg;
        mem_we   = (r_state == mcaam_pkg::ST_UPD) && do_write;
        n_vmask  = r_vmask;
        if (do_write && is_audio && r_allow) begin
            n_vmask[bit_pos] = (adiff <= AW'(r_tol));
        end
    end

    // mic current from the two registered products
    logic [MW:0]          mic_diff;
    logic [mcaam_pkg::MIC_W-1:0] mic;

    always_comb begin
        mic_diff = {1'b0, r_pa} - {1'b0, r_pb};
        if (!mic_diff[MW] && (mic_diff[MW-1:mcaam_pkg::MIC_SHIFT + mcaam_pkg::MIC_W] == '0)) begin
            mic = mic_diff[mcaam_pkg::MIC_SHIFT +: mcaam_pkg::MIC_W];
        end else begin
            mic = '0;
        end
    end

    // sequencer
    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        div_start     = 1'b0;
        out_load      = 1'b0;
        unique case (r_state)
            mcaam_pkg::ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_state = mcaam_pkg::ST_LOOK;
                end
            end
            mcaam_pkg::ST_LOOK: begin
                if ((r_act == mcaam_pkg::ACT_SAMPLE) && ch_ok && is_ant && !ant_sat) begin
                    div_start = 1'b1;
                    n_state   = mcaam_pkg::ST_DIV;
                end else begin
                    n_state = mcaam_pkg::ST_UPD;
                end
            end
            mcaam_pkg::ST_DIV: begin
                if (div_done) begin
                    n_state = mcaam_pkg::ST_UPD;
                end
            end
            mcaam_pkg::ST_UPD:     n_state = mcaam_pkg::ST_RD_SUP;
            mcaam_pkg::ST_RD_SUP:  n_state = mcaam_pkg::ST_RD_PLUS;
            mcaam_pkg::ST_RD_PLUS: n_state = mcaam_pkg::ST_MIC;
            mcaam_pkg::ST_MIC:     n_state = mcaam_pkg::ST_DONE;
            mcaam_pkg::ST_DONE: begin
                if (!r_ovld || m_axis_tready) begin
                    out_load = 1'b1;
                    n_state  = mcaam_pkg::ST_IDLE;
                end
            end
            default: n_state = mcaam_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mcaam_pkg::ST_IDLE;
            r_valid <= '0;
            r_vmask <= '0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == mcaam_pkg::ST_UPD) begin
                r_vmask <= n_vmask;
                if (r_act == mcaam_pkg::ACT_CLEAR) begin
                    r_valid <= '0;
                end else if (do_write) begin
                    r_valid[r_ch] <= 1'b1;
                end
            end
            if (out_load) begin
                r_ovld <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_act   <= mcaam_pkg::t_action'(s_axis_tuser);
            r_ch    <= in_ch;
            r_smp   <= s_axis_tdata[15:4];
            r_batt  <= s_axis_tdata[27:16];
            r_allow <= s_axis_tdata[28];
            r_prod  <= s_axis_tdata[15:4] * r_ant_scale;
        end
        if (r_state == mcaam_pkg::ST_LOOK) begin
            r_old <= rd_val;
            if (is_ant && ant_sat) begin
                r_v <= '1;
            end else begin
                r_v <= smp_ext;
            end
        end
        if ((r_state == mcaam_pkg::ST_DIV) && div_done) begin
            r_v <= div_quot;
        end
        if (r_state == mcaam_pkg::ST_UPD) begin
            if (do_write) begin
                r_avg <= wr_data;
            end else if ((r_act == mcaam_pkg::ACT_CLEAR) || !ch_ok) begin
                r_avg <= '0;
            end else begin
                r_avg <= r_old;
            end
        end
        if (r_state == mcaam_pkg::ST_RD_PLUS) begin
            r_pa <= rd_val * r_sup_gain;
        end
        if (r_state == mcaam_pkg::ST_MIC) begin
            r_pb <= rd_val * r_plus_gain;
        end
        if (out_load) begin
            r_odata <= {4'b0, mic, r_vmask, r_avg};
        end
    end

    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = r_odata;

    // validity mask moves only on the update step
    a_vmask_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != mcaam_pkg::ST_UPD) |=> $stable(r_vmask))
        else $error("valid mask changed outside update");

    // divider finishes only while the sequencer waits on it
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == mcaam_pkg::ST_DIV))
        else $error("divider done outside divide state");

    // a finished item with a free output register is loaded at once
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == mcaam_pkg::ST_DONE) && !r_ovld) |=> (r_ovld && (r_state == mcaam_pkg::ST_IDLE)))
        else $error("result not loaded");

    // memory is written only on a sample beat for a real channel
    a_mem_we: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (ch_ok && (r_act == mcaam_pkg::ACT_SAMPLE)))
        else $error("bad average write");

endmodule

>>> dv/adc_average_checker.sv
`timescale 1ns / 1ps
// predicts and compares every result beat of the adc averager stream ports
module adc_average_checker
    import mcaam_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // channel, sample, battery_sample, audio_allowed
    input  logic [1:0]  s_axis_tuser,   // action
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,   // average, valid_mask, mic_current
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          o_err_count,
    output int          o_beats_checked
);

    typedef struct packed {
        logic [AVG_W-1:0]  average;
        logic [MASK_W-1:0] valid_mask;
        logic [MIC_W-1:0]  mic_current;
    } t_report;

    logic [AVG_W-1:0]  avg_mem [NUM_CHANNELS];
    logic [MASK_W-1:0] valid_bits;
    logic [GAIN_W-1:0] ant_scale;
    logic [GAIN_W-1:0] sup_gain;
    logic [GAIN_W-1:0] plus_gain;
    logic [TOL_W-1:0]  tolerance;
    t_report           expected_reports [$];
    int                errors;

    function automatic logic [AVG_W-1:0] antenna_ratio(input logic [SAMPLE_W-1:0] smp,
                                                       input logic [SAMPLE_W-1:0] batt);
        longint unsigned q;
        if (batt == '0) begin
            return '1;
        end
        q = (64'(smp) * 64'(ant_scale)) / 64'(batt);
        return (q > 65535) ? '1 : q[AVG_W-1:0];
    endfunction

    function automatic logic [MIC_W-1:0] mic_drain();
        longint sup;
        longint plus;
        longint d;
        sup  = avg_mem[CH_SUPPLY];
        plus = avg_mem[CH_MIC_PLUS];
        d = sup * longint'(sup_gain) - plus * longint'(plus_gain);
        // negative or above eight bits reads as zero
        if (d < 0 || (d >> MIC_SHIFT) > 255) begin
            return '0;
        end
        return MIC_W'(d >> MIC_SHIFT);
    endfunction

    function automatic t_report apply_scan(input t_action act, input logic [CH_W-1:0] ch,
                                           input logic [SAMPLE_W-1:0] smp,
                                           input logic [SAMPLE_W-1:0] batt,
                                           input logic allowed);
        t_report     r;
        int unsigned v;
        int unsigned avg_new;
        int unsigned gap;
        logic        audio;
        audio = (ch >= CH_LEFT_PLUS) && (ch <= CH_RIGHT_MINUS);
        if (act == ACT_CLEAR) begin
            foreach (avg_mem[i]) avg_mem[i] = '0;
        end else if (act == ACT_SAMPLE && ch < NUM_CHANNELS) begin
            if (audio && !allowed) begin
                avg_mem[ch] = AVG_W'(smp);
            end else begin
                v = (ch == CH_ANTENNA) ? antenna_ratio(smp, batt) : smp;
                avg_new = (avg_mem[ch] + v) >> 1;
                avg_mem[ch] = AVG_W'(avg_new);
                if (audio) begin
                    gap = (avg_new >= smp) ? avg_new - smp : smp - avg_new;
                    valid_bits[CH_RIGHT_MINUS - ch] = (gap <= tolerance);
                end
            end
        end
        r.average     = (ch < NUM_CHANNELS) ? avg_mem[ch] : '0;
        r.valid_mask  = valid_bits;
        r.mic_current = mic_drain();
        return r;
    endfunction

    task automatic flag_beat(input string what, input t_report want, input t_report seen);
        errors++;
        if (errors <= 10) begin
            $display("mismatch %0d (%s): expected avg=%0d mask=%b mic=%0d, got avg=%0d mask=%b mic=%0d",
                     errors, what, want.average, want.valid_mask, want.mic_current,
                     seen.average, seen.valid_mask, seen.mic_current);
        end
    endtask

    always @(posedge i_clk) begin
        t_report seen;
        t_report want;
        if (!i_rst_n) begin
            foreach (avg_mem[i]) avg_mem[i] = '0;
            valid_bits = '0;
            ant_scale  = ANT_SCALE_RST;
            sup_gain   = SUP_GAIN_RST;
            plus_gain  = PLUS_GAIN_RST;
            tolerance  = TOL_RST;
            expected_reports.delete();
            errors = 0;
            o_err_count     <= 0;
            o_beats_checked <= 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (t_reg_idx'(paddr[3:2]))
                    REG_ANT_SCALE: ant_scale = pwdata[GAIN_W-1:0];
                    REG_SUP_GAIN:  sup_gain  = pwdata[GAIN_W-1:0];
                    REG_PLUS_GAIN: plus_gain = pwdata[GAIN_W-1:0];
                    REG_TOL:       tolerance = pwdata[TOL_W-1:0];
                    default: ;
                endcase
            end
            // a result beat always belongs to an earlier scan beat, so compare first
            if (m_axis_tvalid && m_axis_tready) begin
                seen.average     = m_axis_tdata[15:0];
                seen.valid_mask  = m_axis_tdata[19:16];
                seen.mic_current = m_axis_tdata[27:20];
                o_beats_checked <= o_beats_checked + 1;
                if (expected_reports.size() == 0) begin
                    flag_beat("no result expected", '0, seen);
                end else begin
                    want = expected_reports.pop_front();
                    if (seen.average !== want.average || seen.valid_mask !== want.valid_mask
                            || seen.mic_current !== want.mic_current) begin
                        flag_beat("field differs", want, seen);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                expected_reports.push_back(apply_scan(t_action'(s_axis_tuser),
                    s_axis_tdata[3:0], s_axis_tdata[15:4], s_axis_tdata[27:16],
                    s_axis_tdata[28]));
            end
            o_err_count <= errors;
        end
    end

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
// testbench top: clock, reset, scan stimulus, register settings and verdict
module testbench;
    import mcaam_pkg::*;

    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 32;
    localparam int PHASE_ITEMS  = 204;
    localparam int NUM_PHASES   = 8;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int send_idle_pct = 0;
    int stall_pct = 0;
    int items_sent = 0;
    int quiet_cycles = 0;
    int err_count;
    int beats_checked;

    multichannel_adc_averager_monitor_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    adc_average_checker scan_check (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .o_err_count(err_count), .o_beats_checked(beats_checked)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    // ends a hung run: counts cycles with no beat on either stream
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no beat for %0d cycles", QUIET_LIMIT);
            $display("testbench: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_scan(input t_action act, input logic [CH_W-1:0] ch,
                             input logic [SAMPLE_W-1:0] smp, input logic [SAMPLE_W-1:0] batt,
                             input logic allowed);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {3'b000, allowed, batt, smp, ch};
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
    endtask

    // leaves psel high; the caller drops it after the last write
    task automatic write_reg(input t_reg_idx idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
    endtask

    task automatic wait_drain();
        while (beats_checked < items_sent) @(posedge i_clk);
    endtask

    function automatic logic [CH_W-1:0] pick_channel();
        int r;
        r = $urandom_range(99);
        if (r < 40) begin
            return CH_W'($urandom_range(CH_RIGHT_MINUS, CH_LEFT_PLUS));
        end
        if (r < 55) begin
            return CH_ANTENNA;
        end
        if (r < 70) begin
            return r[0] ? CH_SUPPLY : CH_MIC_PLUS;
        end
        return CH_W'($urandom_range(NUM_CHANNELS - 1));
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        int r;
        r = $urandom_range(9);
        case (r)
            0:       return '0;
            1:       return '1;
            2, 3, 4: return SAMPLE_W'($urandom_range(255));
            default: return SAMPLE_W'($urandom_range(4095));
        endcase
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_battery();
        int r;
        r = $urandom_range(9);
        if (r == 0) begin
            return '0;
        end
        // small battery values push the antenna ratio past 16 bits
        if (r < 3) begin
            return SAMPLE_W'($urandom_range(255, 1));
        end
        return SAMPLE_W'($urandom_range(4095));
    endfunction

    task automatic run_random(input int goal);
        int done_cnt;
        int pick;
        int burst_len;
        logic [CH_W-1:0] ch;
        logic [SAMPLE_W-1:0] base;
        done_cnt = 0;
        while (done_cnt < goal) begin
            pick = $urandom_range(99);
            if (pick < 60) begin
                // runs of close samples on one channel let the average settle
                ch = pick_channel();
                base = pick_sample();
                burst_len = $urandom_range(6, 1);
                for (int k = 0; k < burst_len; k++) begin
                    send_scan(ACT_SAMPLE, ch, base ^ SAMPLE_W'($urandom_range(3)),
                              pick_battery(), $urandom_range(9) != 0);
                end
                done_cnt += burst_len;
            end else if (pick < 75) begin
                send_scan(ACT_READ, CH_W'($urandom_range(15)), pick_sample(),
                          pick_battery(), $urandom_range(1));
                done_cnt++;
            end else if (pick < 79) begin
                send_scan(ACT_CLEAR, CH_W'($urandom_range(15)), pick_sample(),
                          pick_battery(), $urandom_range(1));
                done_cnt++;
            end else if (pick < 84) begin
                send_scan(ACT_NONE, CH_W'($urandom_range(15)), pick_sample(),
                          pick_battery(), $urandom_range(1));
                done_cnt++;
            end else if (pick < 90) begin
                send_scan(ACT_SAMPLE, CH_W'($urandom_range(15, NUM_CHANNELS)), pick_sample(),
                          pick_battery(), $urandom_range(1));
                done_cnt++;
            end else begin
                send_scan(t_action'($urandom_range(3)), CH_W'($urandom_range(15)),
                          SAMPLE_W'($urandom), SAMPLE_W'($urandom), $urandom_range(1));
                done_cnt++;
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed beats under the reset register values
        send_scan(ACT_READ,   4'd0,  12'd0,    12'd0,    1'b1);
        send_scan(ACT_SAMPLE, CH_SUPPLY,   12'd4095, 12'd100, 1'b1); // mic current too high
        send_scan(ACT_SAMPLE, CH_MIC_PLUS, 12'd0,    12'd100, 1'b1);
        send_scan(ACT_SAMPLE, CH_MIC_PLUS, 12'd4095, 12'd100, 1'b1); // negative drain
        send_scan(ACT_SAMPLE, CH_ANTENNA,  12'd4095, 12'd0,   1'b1); // zero battery
        send_scan(ACT_SAMPLE, CH_ANTENNA,  12'd4095, 12'd1,   1'b1); // ratio overflow
        send_scan(ACT_SAMPLE, CH_ANTENNA,  12'd1000, 12'd2000, 1'b1);
        send_scan(ACT_SAMPLE, 4'd3, 12'd100,  12'd0, 1'b1);  // far from sample, bit clears
        send_scan(ACT_SAMPLE, 4'd3, 12'd100,  12'd0, 1'b0);  // audio off loads raw sample
        send_scan(ACT_SAMPLE, 4'd3, 12'd100,  12'd0, 1'b1);  // close, bit sets
        send_scan(ACT_SAMPLE, 4'd4, 12'd4095, 12'd0, 1'b1);
        send_scan(ACT_SAMPLE, 4'd5, 12'd0,    12'd0, 1'b1);
        send_scan(ACT_SAMPLE, 4'd6, 12'd4095, 12'd0, 1'b0);
        send_scan(ACT_SAMPLE, 4'd6, 12'd4095, 12'd0, 1'b1);
        send_scan(ACT_SAMPLE, 4'd13, 12'd4095, 12'd4095, 1'b1); // ignored channel
        send_scan(ACT_READ,   4'd15, 12'd0,    12'd0,    1'b0);
        send_scan(ACT_NONE,   CH_SUPPLY, 12'd4095, 12'd4095, 1'b1);
        send_scan(ACT_CLEAR,  4'd2,  12'd0,   12'd0, 1'b1);  // valid mask bits survive
        send_scan(ACT_READ,   4'd3,  12'd0,   12'd0, 1'b1);
        send_scan(ACT_SAMPLE, CH_SUPPLY,   12'd600, 12'd0, 1'b1); // in-range drain
        send_scan(ACT_SAMPLE, CH_MIC_PLUS, 12'd100, 12'd0, 1'b1);
        send_scan(ACT_SAMPLE, 4'd0,  12'd4095, 12'd0, 1'b1);
        send_scan(ACT_SAMPLE, 4'd12, 12'd4095, 12'd0, 1'b0);
        send_scan(ACT_SAMPLE, 4'd11, 12'd1234, 12'd0, 1'b0);
        s_axis_tvalid <= 1'b0;
        wait_drain();

        for (int p = 0; p < NUM_PHASES; p++) begin
            send_idle_pct = (p % 4 == 1) ? 54 : (p % 4 == 3) ? 21 : 0;
            stall_pct     = (p % 4 == 2) ? 54 : (p % 4 == 3) ? 21 : 0;
            case (p)
                0: begin
                    write_reg(REG_ANT_SCALE, 32'd666);
                    write_reg(REG_SUP_GAIN,  32'd339);
                    write_reg(REG_PLUS_GAIN, 32'd620);
                    write_reg(REG_TOL,       32'd1);
                end
                1: begin
                    write_reg(REG_ANT_SCALE, 32'd4095);
                    write_reg(REG_SUP_GAIN,  32'd4095);
                    write_reg(REG_PLUS_GAIN, 32'd4095);
                    write_reg(REG_TOL,       32'd255);
                end
                2: begin
                    write_reg(REG_ANT_SCALE, 32'd0);
                    write_reg(REG_SUP_GAIN,  32'd0);
                    write_reg(REG_PLUS_GAIN, 32'd0);
                    write_reg(REG_TOL,       32'd0);
                end
                4: begin
                    write_reg(REG_ANT_SCALE, 32'd4095);
                    write_reg(REG_SUP_GAIN,  32'($urandom_range(400)));
                    write_reg(REG_PLUS_GAIN, 32'($urandom_range(400)));
                    write_reg(REG_TOL,       32'd0);
                end
                6: begin
                    write_reg(REG_ANT_SCALE, 32'd666);
                    write_reg(REG_SUP_GAIN,  32'd339);
                    write_reg(REG_PLUS_GAIN, 32'd620);
                    write_reg(REG_TOL,       32'd255);
                end
                default: begin
                    // upper data bits are junk the registers must drop
                    write_reg(REG_ANT_SCALE, $urandom);
                    write_reg(REG_SUP_GAIN,  $urandom);
                    write_reg(REG_PLUS_GAIN, $urandom);
                    write_reg(REG_TOL,       $urandom);
                end
            endcase
            psel    <= 1'b0;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            run_random(PHASE_ITEMS);
            s_axis_tvalid <= 1'b0;
            wait_drain();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("summary: %0d scan beats in, %0d result beats compared", items_sent,
                 beats_checked);
        $display("summary: %0d register settings, with and without idle and backpressure",
                 NUM_PHASES + 1);
        if (err_count == 0 && beats_checked == items_sent) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule

>>> multichannel_adc_averager_monitor_core.f
hdl/mcaam_pkg.sv
hdl/mcaam_div.sv
hdl/multichannel_adc_averager_monitor_core.sv
dv/adc_average_checker.sv
dv/testbench.sv
